// ===== hdl/mzc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mzc_pkg;

   // grid side bound, minimum side and power-up side
   localparam int MAX_SIDE_DEFAULT = 63;
   localparam logic [5:0] SIDE_RESET = 6'd21;
   localparam logic [5:0] SIDE_MIN = 6'd5;

   // probe counter: one step per direction, one more to take the last read
   localparam logic [2:0] PROBE_LAST = 3'd4;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      KIND_PASSAGE = 2'd0,
      KIND_ROOM    = 2'd1,
      KIND_EXIT    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START_OUT,
      ST_PROBE,
      ST_POP,
      ST_MARK,
      ST_MARK_WR,
      ST_WALL_OUT,
      ST_ROOM_OUT,
      ST_EXIT_OUT
   } state_type;

   // result of one neighbour step
   typedef struct packed {
      logic       inb;
      logic [5:0] row;
      logic [5:0] col;
   } nbr_type;

   // largest usable odd side, bounded by the 6-bit side register
   function automatic int calc_top_side(int max_side);
      int s;
      s = (max_side - 1) | 1;
      if (s > 63) s = 63;
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mzc_nbr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mzc_nbr import mzc_pkg::*; (
   input  wire logic [5:0] here_row,
   input  wire logic [5:0] here_col,
   input  wire logic [1:0] dir,
   input  wire logic [5:0] lim,
   output nbr_type         nbr
);

   logic [6:0] row_up;
   logic [6:0] col_up;

   assign row_up = {1'b0, here_row} + 7'd2;
   assign col_up = {1'b0, here_col} + 7'd2;

   always_comb begin
      nbr.inb = 1'b0;
      nbr.row = here_row;
      nbr.col = here_col;
      case (dir)
         DIR_UP: begin
            nbr.inb = (here_row >= 6'd3);
            nbr.row = here_row - 6'd2;
         end
         DIR_DOWN: begin
            nbr.inb = (row_up <= {1'b0, lim});
            nbr.row = row_up[5:0];
         end
         DIR_LEFT: begin
            nbr.inb = (here_col >= 6'd3);
            nbr.col = here_col - 6'd2;
         end
         default: begin
            nbr.inb = (col_up <= {1'b0, lim});
            nbr.col = col_up[5:0];
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/mzc_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mzc_map import mzc_pkg::*; #(
   parameter  int MAX_SIDE = MAX_SIDE_DEFAULT,
   localparam int HALF     = (calc_top_side(MAX_SIDE) - 1) / 2,
   localparam int RW       = $clog2(HALF)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [RW-1:0] rd_row,
   input  wire logic [RW-1:0] rd_col,
   input  wire logic          set_en,
   input  wire logic          clr_en,
   input  wire logic [RW-1:0] clr_row,
   output logic               seen
);

   // one bit per room cell, one row of rooms per word
   logic [HALF-1:0] mem [HALF];
   logic [HALF-1:0] row_data_ff;
   logic [RW-1:0]   row_ff;
   logic [RW-1:0]   col_ff;

   always_ff @(posedge clock) begin
      if (clr_en) begin
         // the start room is opened by the clear of the first row
         mem[clr_row] <= (clr_row == '0) ? HALF'(1) : '0;
      end else if (set_en) begin
         mem[row_ff] <= row_data_ff | (HALF'(1) << col_ff);
      end
      if (rd_en) begin
         row_data_ff <= mem[rd_row];
         row_ff      <= rd_row;
         col_ff      <= rd_col;
      end
   end

   assign seen = row_data_ff[col_ff];

endmodule

`default_nettype wire

// ===== hdl/mzc_trail.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mzc_trail import mzc_pkg::*; #(
   parameter  int MAX_SIDE = MAX_SIDE_DEFAULT,
   localparam int HALF     = (calc_top_side(MAX_SIDE) - 1) / 2,
   localparam int CAP      = HALF * HALF + 1,
   localparam int SW       = $clog2(CAP),
   localparam int DW       = $clog2(CAP + 1)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        clear,
   input  wire logic        push,
   input  wire logic [11:0] push_data,
   input  wire logic        pop,
   output logic [11:0]      pop_data,
   output logic             empty
);

   logic [11:0]   mem [CAP];
   logic [DW-1:0] depth_ff;
   logic [DW-1:0] depth_in;
   logic [DW-1:0] depth_dec;
   logic [11:0]   pop_data_ff;

   assign depth_dec = depth_ff - 1'b1;
   assign empty     = (depth_ff == '0);
   assign pop_data  = pop_data_ff;

   always_comb begin
      depth_in = depth_ff;
      if (clear) begin
         depth_in = '0;
      end else if (pop && !empty) begin
         depth_in = depth_dec;
      end else if (push && (depth_ff < DW'(CAP))) begin
         depth_in = depth_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !clear && (depth_ff < DW'(CAP))) begin
         mem[depth_ff[SW-1:0]] <= push_data;
      end
      if (pop && !empty) begin
         pop_data_ff <= mem[depth_dec[SW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/backtracking_maze_carver_unit.sv =====
// Channel  | Dir | Handshake        | Payload
// req      | in  | tvalid / tready  | tdata: direction; tuser: mode
// rsp      | out | tvalid / tready  | tdata: cell_row, cell_col; tuser: kind, done_res; tlast
// csr      | in  | wr_en            | wr_data: side_length
//
// A start clears one visited-map row per cycle, then loads the start result. A draw
// examines each stack level with four map reads through one neighbour unit and one map
// port, plus a pop for each level left, then reads and writes the map to mark it and
// loads the results while rsp_tready is high.
// req_tready is high only between items; the last result may still wait in the output
// register while the next item is taken. Reset is synchronous and clears the control
// state; the visited map is cleared by each start, not by reset.
`timescale 1ns / 1ps
`default_nettype none

module backtracking_maze_carver_unit import mzc_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [1:0] direction, [7:2] zero
   input  wire logic [0:0]  req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [5:0] cell_row, [11:6] cell_col, [15:12] zero
   output logic [2:0]       rsp_tuser,   // [1:0] kind, [2] done_res
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   localparam int TOP_SIDE = calc_top_side(MAX_SIDE);
   localparam int HALF     = (TOP_SIDE - 1) / 2;
   localparam int RW       = $clog2(HALF);
   localparam int CW       = $clog2(HALF * HALF + 1);

   state_type     state_ff, state_in;
   logic [5:0]    side_ff;
   logic [5:0]    run_side_ff, run_side_in;
   logic [5:0]    lim_ff, lim_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] cells_ff, cells_in;
   logic [CW-1:0] cells_next;
   logic [5:0]    here_row_ff, here_row_in;
   logic [5:0]    here_col_ff, here_col_in;
   logic          running_ff, running_in;
   logic [1:0]    dir_ff, dir_in;
   logic [2:0]    k_ff, k_in;
   logic          inb_ff, inb_in;
   logic [3:0]    mask_ff, mask_in;
   logic [3:0]    mask_next;
   logic [1:0]    mask_idx;
   logic [5:0]    nr_ff, nr_in;
   logic [5:0]    nc_ff, nc_in;
   logic [5:0]    wr_ff, wr_in;
   logic [5:0]    wc_ff, wc_in;
   logic          done_ff, done_in;
   logic [RW-1:0] clr_ff, clr_in;
   logic [5:0]    eff_side;
   logic [6:0]    wall_row_sum;
   logic [6:0]    wall_col_sum;
   logic [9:0]    total_prod;

   logic [1:0]    nbr_dir;
   nbr_type       nbr;

   logic          map_rd_en, map_set_en, map_clr_en, map_seen;
   logic [RW-1:0] map_rd_row, map_rd_col;

   logic          trail_clear, trail_push, trail_pop, trail_empty;
   logic [11:0]   trail_pop_data;

   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff;
   logic [2:0]    rsp_user_ff;
   logic          rsp_last_ff;
   logic          out_free;
   logic          out_ld;
   logic [5:0]    out_row, out_col;
   kind_type      out_kind;
   logic          out_last, out_done;
   logic          req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      eff_side = side_ff | 6'd1;
      if (eff_side < SIDE_MIN) eff_side = SIDE_MIN;
      if (eff_side > 6'(TOP_SIDE)) eff_side = 6'(TOP_SIDE);
   end

   assign nbr_dir      = (state_ff == ST_MARK) ? dir_ff : k_ff[1:0];
   assign wall_row_sum = {1'b0, here_row_ff} + {1'b0, nbr.row};
   assign wall_col_sum = {1'b0, here_col_ff} + {1'b0, nbr.col};
   assign total_prod   = {5'd0, run_side_ff[5:1]} * {5'd0, run_side_ff[5:1]};
   assign cells_next   = cells_ff + 1'b1;
   assign mask_idx     = k_ff[1:0] - 2'd1;

   mzc_nbr u_nbr (
      .here_row (here_row_ff),
      .here_col (here_col_ff),
      .dir      (nbr_dir),
      .lim      (lim_ff),
      .nbr      (nbr)
   );

   mzc_map #(.MAX_SIDE(MAX_SIDE)) u_map (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_row  (map_rd_row),
      .rd_col  (map_rd_col),
      .set_en  (map_set_en),
      .clr_en  (map_clr_en),
      .clr_row (clr_ff),
      .seen    (map_seen)
   );

   mzc_trail #(.MAX_SIDE(MAX_SIDE)) u_trail (
      .clock     (clock),
      .reset     (reset),
      .clear     (trail_clear),
      .push      (trail_push),
      .push_data ({here_row_ff, here_col_ff}),
      .pop       (trail_pop),
      .pop_data  (trail_pop_data),
      .empty     (trail_empty)
   );

   always_comb begin
      state_in    = state_ff;
      run_side_in = run_side_ff;
      lim_in      = lim_ff;
      total_in    = total_ff;
      cells_in    = cells_ff;
      here_row_in = here_row_ff;
      here_col_in = here_col_ff;
      running_in  = running_ff;
      dir_in      = dir_ff;
      k_in        = k_ff;
      inb_in      = inb_ff;
      mask_in     = mask_ff;
      mask_next   = mask_ff;
      nr_in       = nr_ff;
      nc_in       = nc_ff;
      wr_in       = wr_ff;
      wc_in       = wc_ff;
      done_in     = done_ff;
      clr_in      = clr_ff;
      map_rd_en   = 1'b0;
      map_rd_row  = '0;
      map_rd_col  = '0;
      map_set_en  = 1'b0;
      map_clr_en  = 1'b0;
      trail_clear = 1'b0;
      trail_push  = 1'b0;
      trail_pop   = 1'b0;
      out_ld      = 1'b0;
      out_row     = lim_ff;
      out_col     = lim_ff;
      out_kind    = KIND_EXIT;
      out_last    = 1'b1;
      out_done    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_tuser[0]) begin
                  run_side_in = eff_side;
                  lim_in      = eff_side - 6'd2;
                  here_row_in = 6'd1;
                  here_col_in = 6'd1;
                  cells_in    = CW'(1);
                  running_in  = 1'b1;
                  trail_clear = 1'b1;
                  clr_in      = RW'(HALF - 1);
                  state_in    = ST_CLEAR;
               end else if (running_ff) begin
                  dir_in   = req_tdata[1:0];
                  k_in     = '0;
                  state_in = ST_PROBE;
               end
            end
         end

         ST_CLEAR: begin
            map_clr_en = 1'b1;
            total_in   = CW'(total_prod);
            if (clr_ff == '0) begin
               state_in = ST_START_OUT;
            end else begin
               clr_in = clr_ff - 1'b1;
            end
         end

         ST_START_OUT: begin
            if (out_free) begin
               out_ld   = 1'b1;
               out_row  = 6'd1;
               out_col  = 6'd1;
               out_kind = KIND_ROOM;
               out_last = 1'b1;
               out_done = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_PROBE: begin
            // issue the read for direction k, judge direction k-1 from the last read
            if (k_ff != PROBE_LAST) begin
               map_rd_en = 1'b1;
               if (nbr.inb) begin
                  map_rd_row = nbr.row[RW:1];
                  map_rd_col = nbr.col[RW:1];
               end
               inb_in = nbr.inb;
            end
            if (k_ff == '0) begin
               mask_next = '0;
            end else begin
               mask_next[mask_idx] = inb_ff && !map_seen;
            end
            mask_in = mask_next;
            k_in    = k_ff + 1'b1;
            if (k_ff == PROBE_LAST) begin
               if (mask_next != '0) begin
                  state_in = mask_next[dir_ff] ? ST_MARK : ST_IDLE;
               end else if (trail_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  trail_pop = 1'b1;
                  state_in  = ST_POP;
               end
            end
         end

         ST_POP: begin
            here_row_in = trail_pop_data[11:6];
            here_col_in = trail_pop_data[5:0];
            k_in        = '0;
            state_in    = ST_PROBE;
         end

         ST_MARK: begin
            map_rd_en   = 1'b1;
            map_rd_row  = nbr.row[RW:1];
            map_rd_col  = nbr.col[RW:1];
            nr_in       = nbr.row;
            nc_in       = nbr.col;
            wr_in       = wall_row_sum[6:1];
            wc_in       = wall_col_sum[6:1];
            trail_push  = 1'b1;
            here_row_in = nbr.row;
            here_col_in = nbr.col;
            state_in    = ST_MARK_WR;
         end

         ST_MARK_WR: begin
            map_set_en = 1'b1;
            cells_in   = cells_next;
            done_in    = (cells_next >= total_ff);
            state_in   = ST_WALL_OUT;
         end

         ST_WALL_OUT: begin
            if (out_free) begin
               out_ld   = 1'b1;
               out_row  = wr_ff;
               out_col  = wc_ff;
               out_kind = KIND_PASSAGE;
               out_last = 1'b0;
               out_done = done_ff;
               state_in = ST_ROOM_OUT;
            end
         end

         ST_ROOM_OUT: begin
            if (out_free) begin
               out_ld   = 1'b1;
               out_row  = nr_ff;
               out_col  = nc_ff;
               out_kind = KIND_ROOM;
               out_last = !done_ff;
               out_done = done_ff;
               if (done_ff) begin
                  running_in = 1'b0;
                  state_in   = ST_EXIT_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EXIT_OUT: begin
            if (out_free) begin
               out_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= SIDE_RESET;
         run_side_ff  <= SIDE_RESET;
         lim_ff       <= SIDE_RESET - 6'd2;
         cells_ff     <= '0;
         here_row_ff  <= 6'd1;
         here_col_ff  <= 6'd1;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         run_side_ff <= run_side_in;
         lim_ff      <= lim_in;
         cells_ff    <= cells_in;
         here_row_ff <= here_row_in;
         here_col_ff <= here_col_in;
         running_ff  <= running_in;
         if (csr_wr_en) begin
            side_ff <= csr_wr_data;
         end
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      dir_ff   <= dir_in;
      k_ff     <= k_in;
      inb_ff   <= inb_in;
      mask_ff  <= mask_in;
      nr_ff    <= nr_in;
      nc_ff    <= nc_in;
      wr_ff    <= wr_in;
      wc_ff    <= wc_in;
      done_ff  <= done_in;
      clr_ff   <= clr_in;
      if (out_ld) begin
         rsp_data_ff <= {4'd0, out_col, out_row};
         rsp_user_ff <= {out_done, out_kind};
         rsp_last_ff <= out_last;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mzc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mzc_checker import mzc_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // exit marker closes a finished maze
   a_exit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_EXIT) |-> rsp_tlast && rsp_tuser[2])
      else $error("exit marker without last or done");

   // a passage is never marked last; its room always follows
   a_wall_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_PASSAGE) |-> !rsp_tlast)
      else $error("passage word marked last");

   // exit sits on the diagonal corner
   a_exit_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_EXIT) |-> rsp_tdata[5:0] == rsp_tdata[11:6])
      else $error("exit marker off the diagonal");

endmodule

bind backtracking_maze_carver_unit mzc_checker u_mzc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
